// File: rtl/ssf_pkg.sv
// Shared types, constants and register codes for the selectable smoothing filter.
// Depends on nothing; every other file imports it.

package ssf_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS       = PROD_BITS + 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int FILL_BITS      = 3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [PROD_BITS-1:0]   t_prod;
    typedef logic signed [ACC_BITS-1:0]    t_acc;
    typedef logic [1:0]                    t_mode;
    typedef logic [CFG_INDEX_BITS-1:0]     t_cfg_index;
    typedef logic [FILL_BITS-1:0]          t_fill;

    localparam t_mode MODE_MEAN = 2'd0;
    localparam t_mode MODE_IIR  = 2'd1;
    localparam t_mode MODE_SG   = 2'd2;

    localparam t_cfg_index REG_FILTER_MODE = 3'd0;
    localparam t_cfg_index REG_IIR_B0      = 3'd1;
    localparam t_cfg_index REG_IIR_B1      = 3'd2;
    localparam t_cfg_index REG_IIR_B2      = 3'd3;
    localparam t_cfg_index REG_IIR_A1      = 3'd4;
    localparam t_cfg_index REG_IIR_A2      = 3'd5;

    localparam t_mode MODE_RESET   = MODE_MEAN;
    localparam t_coef IIR_B0_RESET = 16'sd220;
    localparam t_coef IIR_B1_RESET = 16'sd437;
    localparam t_coef IIR_B2_RESET = 16'sd220;
    localparam t_coef IIR_A1_RESET = -16'sd26993;
    localparam t_coef IIR_A2_RESET = 16'sd11484;

    // Savitzky-Golay weights k/35, rounded half away from zero
    localparam t_coef SG_W0 = t_coef'(((31 << COEF_FRAC_BITS) * 2 + 35) / 70);
    localparam t_coef SG_W1 = t_coef'(((9 << COEF_FRAC_BITS) * 2 + 35) / 70);
    localparam t_coef SG_W2 = t_coef'(-(((3 << COEF_FRAC_BITS) * 2 + 35) / 70));
    localparam t_coef SG_W3 = t_coef'(-(((5 << COEF_FRAC_BITS) * 2 + 35) / 70));
    localparam t_coef SG_W4 = t_coef'(((3 << COEF_FRAC_BITS) * 2 + 35) / 70);

    localparam t_fill SG_TAPS = t_fill'(5);

    typedef struct packed {
        t_mode mode;
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_cfg;

endpackage

// File: rtl/ssf_if.sv
// Channel interfaces: input sample, output sample and register write.
// Depends on ssf_pkg.

interface ssf_in_if import ssf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface ssf_out_if import ssf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

interface ssf_cfg_if import ssf_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_coef      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/ssf_cfg_regs.sv
// Configuration register file: filter mode and biquad coefficients.
// Depends on ssf_pkg and ssf_cfg_if.

module ssf_cfg_regs import ssf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssf_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= MODE_RESET;
            r_cfg.b0   <= IIR_B0_RESET;
            r_cfg.b1   <= IIR_B1_RESET;
            r_cfg.b2   <= IIR_B2_RESET;
            r_cfg.a1   <= IIR_A1_RESET;
            r_cfg.a2   <= IIR_A2_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_FILTER_MODE: r_cfg.mode <= i_cfg.data[$bits(t_mode)-1:0];
                REG_IIR_B0:      r_cfg.b0   <= i_cfg.data;
                REG_IIR_B1:      r_cfg.b1   <= i_cfg.data;
                REG_IIR_B2:      r_cfg.b2   <= i_cfg.data;
                REG_IIR_A1:      r_cfg.a1   <= i_cfg.data;
                REG_IIR_A2:      r_cfg.a2   <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/ssf_filter.sv
// Filter datapath: two-tap mean, biquad and five-tap Savitzky-Golay with their histories.
// Depends on ssf_pkg; histories advance on i_step for the selected mode only.

module ssf_filter import ssf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_sample i_x,
    input  t_cfg    i_cfg,
    output t_sample o_y
);

    localparam t_acc ACC_SMAX = (t_acc'(1) <<< (SAMPLE_BITS - 1)) - t_acc'(1);
    localparam t_acc ACC_SMIN = -ACC_SMAX - t_acc'(1);
    localparam t_acc ACC_HALF = t_acc'(1) <<< (COEF_FRAC_BITS - 1);

    function automatic t_sample round_sat(input t_acc acc);
        t_acc shifted;
        shifted = (acc + ACC_HALF) >>> COEF_FRAC_BITS;
        if (shifted > ACC_SMAX) begin
            return t_sample'(ACC_SMAX);
        end else if (shifted < ACC_SMIN) begin
            return t_sample'(ACC_SMIN);
        end
        return shifted[SAMPLE_BITS-1:0];
    endfunction

    t_sample r_iir_x1, r_iir_x2, r_iir_y1, r_iir_y2;
    t_sample r_mean_prev;
    logic    r_mean_started;
    t_sample r_sg_h0, r_sg_h1, r_sg_h2, r_sg_h3;
    t_fill   r_fill;

    t_prod   w_pb0, w_pb1, w_pb2, w_pa1, w_pa2;
    t_prod   w_ps0, w_ps1, w_ps2, w_ps3, w_ps4;
    t_acc    w_acc_iir, w_acc_sg;
    t_sample w_y_iir, w_y_sg, w_y_mean;
    logic signed [SAMPLE_BITS:0] w_mean_sum;
    logic    w_is_iir, w_is_sg, w_is_mean;

    assign w_is_iir  = (i_cfg.mode == MODE_IIR);
    assign w_is_sg   = (i_cfg.mode == MODE_SG);
    assign w_is_mean = !w_is_iir && !w_is_sg;

    assign w_pb0 = i_cfg.b0 * i_x;
    assign w_pb1 = i_cfg.b1 * r_iir_x1;
    assign w_pb2 = i_cfg.b2 * r_iir_x2;
    assign w_pa1 = i_cfg.a1 * r_iir_y1;
    assign w_pa2 = i_cfg.a2 * r_iir_y2;

    assign w_acc_iir = t_acc'(w_pb0) + t_acc'(w_pb1) + t_acc'(w_pb2)
                     - t_acc'(w_pa1) - t_acc'(w_pa2);
    assign w_y_iir   = round_sat(w_acc_iir);

    assign w_ps0 = SG_W0 * i_x;
    assign w_ps1 = SG_W1 * r_sg_h0;
    assign w_ps2 = SG_W2 * r_sg_h1;
    assign w_ps3 = SG_W3 * r_sg_h2;
    assign w_ps4 = SG_W4 * r_sg_h3;

    assign w_acc_sg = t_acc'(w_ps0) + t_acc'(w_ps1) + t_acc'(w_ps2)
                    + t_acc'(w_ps3) + t_acc'(w_ps4);
    assign w_y_sg   = (r_fill < SG_TAPS) ? i_x : round_sat(w_acc_sg);

    assign w_mean_sum = {i_x[SAMPLE_BITS-1], i_x} + {r_mean_prev[SAMPLE_BITS-1], r_mean_prev};
    assign w_y_mean   = r_mean_started ? w_mean_sum[SAMPLE_BITS:1] : i_x;

    always_comb begin
        if (w_is_iir) begin
            o_y = w_y_iir;
        end else if (w_is_sg) begin
            o_y = w_y_sg;
        end else begin
            o_y = w_y_mean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iir_x1       <= '0;
            r_iir_x2       <= '0;
            r_iir_y1       <= '0;
            r_iir_y2       <= '0;
            r_mean_prev    <= '0;
            r_mean_started <= 1'b0;
            r_sg_h0        <= '0;
            r_sg_h1        <= '0;
            r_sg_h2        <= '0;
            r_sg_h3        <= '0;
            r_fill         <= '0;
        end else if (i_step) begin
            if (w_is_iir) begin
                r_iir_x1 <= i_x;
                r_iir_x2 <= r_iir_x1;
                r_iir_y1 <= w_y_iir;
                r_iir_y2 <= r_iir_y1;
            end
            if (w_is_sg) begin
                r_sg_h0 <= i_x;
                r_sg_h1 <= r_sg_h0;
                r_sg_h2 <= r_sg_h1;
                r_sg_h3 <= r_sg_h2;
                if (r_fill < SG_TAPS) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (w_is_mean) begin
                r_mean_prev    <= i_x;
                r_mean_started <= 1'b1;
            end
        end
    end

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SG_TAPS)
        else $error("fill count beyond tap count");

    a_fill_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_is_sg && (r_fill < SG_TAPS)) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("fill count did not advance");

    a_mean_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_is_mean) |=> r_mean_started)
        else $error("mean filter not marked started");

    a_iir_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_is_iir) |=> (r_iir_y2 == $past(r_iir_y1)))
        else $error("biquad output history did not shift");

endmodule

// File: rtl/selectable_smoothing_filter_core.sv
// An accepted sample is held in the input stage register and its result in the output register.
// Throughput: one sample per cycle while the output is not stalled; the combinational
// five-product accumulate closes the biquad feedback through its registered output history.
// Reset (synchronous, active low) empties both stages, clears all filter histories and
// loads the default mode and coefficients.

module selectable_smoothing_filter_core import ssf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssf_in_if.sink     i_sample,
    ssf_out_if.source  o_sample,
    ssf_cfg_if.sink    i_cfg
);

    t_cfg    w_cfg;
    t_sample w_y;
    logic    w_adv;
    logic    w_accept;

    logic    r_s1_valid, n_s1_valid;
    t_sample r_s1_sample, n_s1_sample;
    logic    r_out_valid, n_out_valid;
    t_sample r_out_sample, n_out_sample;

    ssf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    ssf_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_x     (r_s1_sample),
        .i_cfg   (w_cfg),
        .o_y     (w_y)
    );

    assign w_adv          = r_s1_valid && (!r_out_valid || o_sample.ready);
    assign i_sample.ready = !r_s1_valid || w_adv;
    assign w_accept       = i_sample.valid && i_sample.ready;

    assign o_sample.valid      = r_out_valid;
    assign o_sample.sample_out = r_out_sample;

    always_comb begin
        n_s1_valid   = r_s1_valid;
        n_s1_sample  = r_s1_sample;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        if (w_accept) begin
            n_s1_valid  = 1'b1;
            n_s1_sample = i_sample.sample_in;
        end else if (w_adv) begin
            n_s1_valid = 1'b0;
        end
        if (w_adv) begin
            n_out_valid  = 1'b1;
            n_out_sample = w_y;
        end else if (o_sample.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
        r_s1_sample  <= n_s1_sample;
        r_out_sample <= n_out_sample;
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> (!r_s1_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_sample.ready) |-> !i_sample.ready)
        else $error("input taken while both stages are held");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out_valid && (r_out_sample == $past(w_y))))
        else $error("advanced result missing from output register");

    a_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> (r_s1_valid && $stable(r_s1_sample)))
        else $error("held sample lost from input stage");

endmodule

// File: tb/testbench.sv
// Self-checking bench for selectable_smoothing_filter_core: directed extremes, then random
// configuration phases with bursty input and a stalling output. Depends on ssf_pkg and the
// channel interfaces in rtl/ssf_if.sv.

module testbench;
    import ssf_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 4;
    localparam int          RANDOM_ITEMS = 750;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_OFF_LEN = 120;
    localparam longint      RUN_LIMIT    = 5_000_000;
    localparam t_sample     S_MAX        = 16'sh7fff;
    localparam t_sample     S_MIN        = 16'sh8000;
    localparam longint      SAMPLE_MAX   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint      SAMPLE_MIN   = -SAMPLE_MAX - 1;
    localparam longint      ROUND_HALF   = longint'(1) <<< (COEF_FRAC_BITS - 1);
    localparam t_mode       MODE_SPARE   = 2'd3;
    localparam t_cfg_index  REG_SPARE_LO = 3'd6;
    localparam t_cfg_index  REG_SPARE_HI = 3'd7;
    localparam longint      SG_WEIGHT[5] = '{14512, 4213, -1404, -2341, 1404};

    class sample_scoreboard;
        t_mode            mode;
        t_coef            b0, b1, b2, a1, a2;
        t_sample          iir_x[2];
        t_sample          iir_y[2];
        t_sample          mean_prev;
        bit               mean_started;
        t_sample          sg_x[4];
        int               sg_fill;
        t_sample          expected_q[$];
        int               mismatches;
        int               checked;

        function new();
            mode = MODE_MEAN;
            b0 = 220;
            b1 = 437;
            b2 = 220;
            a1 = -26993;
            a2 = 11484;
            iir_x = '{0, 0};
            iir_y = '{0, 0};
            mean_prev = 0;
            mean_started = 1'b0;
            sg_x = '{0, 0, 0, 0};
            sg_fill = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function t_sample clamp(longint v);
            if (v > SAMPLE_MAX) return S_MAX;
            if (v < SAMPLE_MIN) return S_MIN;
            return t_sample'(v);
        endfunction

        function void write_register(t_cfg_index idx, t_coef val);
            case (idx)
                REG_FILTER_MODE: mode = val[1:0];
                REG_IIR_B0:      b0 = val;
                REG_IIR_B1:      b1 = val;
                REG_IIR_B2:      b2 = val;
                REG_IIR_A1:      a1 = val;
                REG_IIR_A2:      a2 = val;
                default: ;
            endcase
        endfunction

        function void note_sample(t_sample x);
            longint  acc;
            t_sample y;
            int      i;
            case (mode)
                MODE_IIR: begin
                    acc = longint'(b0) * x + longint'(b1) * iir_x[0] + longint'(b2) * iir_x[1]
                        - longint'(a1) * iir_y[0] - longint'(a2) * iir_y[1];
                    y = clamp((acc + ROUND_HALF) >>> COEF_FRAC_BITS);
                    iir_x[1] = iir_x[0];
                    iir_x[0] = x;
                    iir_y[1] = iir_y[0];
                    iir_y[0] = y;
                end
                MODE_SG: begin
                    if (sg_fill < 5) begin
                        sg_fill++;
                        y = x;
                    end else begin
                        acc = SG_WEIGHT[0] * x;
                        for (i = 0; i < 4; i++) acc += SG_WEIGHT[i + 1] * sg_x[i];
                        y = clamp((acc + ROUND_HALF) >>> COEF_FRAC_BITS);
                    end
                    sg_x[3] = sg_x[2];
                    sg_x[2] = sg_x[1];
                    sg_x[1] = sg_x[0];
                    sg_x[0] = x;
                end
                default: begin
                    if (!mean_started) begin
                        y = x;
                        mean_started = 1'b1;
                    end else begin
                        y = clamp((longint'(x) + mean_prev) >>> 1);
                    end
                    mean_prev = x;
                end
            endcase
            expected_q.push_back(y);
        endfunction

        function void check_result(t_sample got);
            t_sample want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: sample_out %0d with no sample pending", $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                             $time, want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ssf_in_if  in_ch();
    ssf_out_if out_ch();
    ssf_cfg_if cfg_ch();

    sample_scoreboard sb = new();

    bit gaps_on;
    int burst_left;
    int hold_off_len;
    int hold_offs_done;
    int phases;

    selectable_smoothing_filter_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (in_ch.sink),
        .o_sample (out_ch.source),
        .i_cfg    (cfg_ch.sink)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.sample_out);
    end

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3:    return t_sample'(int'($urandom_range(0, 128)) - 64);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_coef pick_wide_coef();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            default: return t_coef'($urandom);
        endcase
    endfunction

    task automatic send_sample(input t_sample x);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= x;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_sample(x);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_coef val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_register(idx, val);
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        phases++;
    endtask

    task automatic write_mode(input t_mode m);
        write_reg(REG_FILTER_MODE, {14'($urandom), m});
    endtask

    // output side: own stall pattern, plus one long hold-off on request
    initial begin
        logic [15:0] pattern;
        int unsigned step;
        pattern = '1;
        step = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_len != 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold_off_len) @(negedge i_clk);
                hold_off_len = 0;
                hold_offs_done++;
            end
            if (step % 48 == 0) pattern = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom);
            out_ch.ready <= pattern[step % 16];
            step++;
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        t_sample mean_pts[6] = '{S_MAX, S_MAX, S_MIN, S_MIN, 16'sd1, -16'sd2};
        t_sample sg_pts[9]   = '{S_MAX, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN, S_MIN, S_MAX,
                                 16'sd0};
        t_sample iir_pts[5]  = '{S_MAX, S_MIN, S_MAX, S_MIN, 16'sd0};
        t_sample spare_pts[3] = '{16'sd100, -16'sd7, S_MIN};
        t_mode   modes[4]    = '{MODE_MEAN, MODE_IIR, MODE_SG, MODE_SPARE};
        t_coef   coefs[5];
        int      random_sent;
        int      n;
        int      kind;
        int      i;

        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_FILTER_MODE;
        cfg_ch.data     = '0;
        gaps_on         = 1'b1;
        burst_left      = 0;
        hold_off_len    = 0;
        hold_offs_done  = 0;
        phases          = 0;
        random_sent     = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: mean from reset, first sample passes through
        foreach (mean_pts[k]) send_sample(mean_pts[k]);
        settle();

        // directed: Savitzky-Golay fill then convolution at full scale; spare indexes ignored
        write_mode(MODE_SG);
        write_reg(REG_SPARE_LO, 16'h5a5a);
        write_reg(REG_SPARE_HI, 16'ha5a5);
        cfg_ch.valid <= 1'b0;
        foreach (sg_pts[k]) send_sample(sg_pts[k]);
        settle();

        // directed: biquad with extreme coefficients
        write_mode(MODE_IIR);
        write_reg(REG_IIR_B0, S_MAX);
        write_reg(REG_IIR_B1, S_MIN);
        write_reg(REG_IIR_B2, S_MAX);
        write_reg(REG_IIR_A1, S_MIN);
        write_reg(REG_IIR_A2, S_MAX);
        cfg_ch.valid <= 1'b0;
        foreach (iir_pts[k]) send_sample(iir_pts[k]);
        settle();

        // directed: unused mode code behaves as the mean
        write_mode(MODE_SPARE);
        cfg_ch.valid <= 1'b0;
        foreach (spare_pts[k]) send_sample(spare_pts[k]);
        settle();

        while (random_sent < RANDOM_ITEMS) begin
            write_mode(modes[$urandom_range(0, 3)]);
            kind = $urandom_range(0, 2);
            for (i = 0; i < 5; i++) begin
                case (kind)
                    0:       coefs = '{220, 437, 220, -26993, 11484};
                    1: begin
                        coefs[i] = (i < 3) ? t_coef'(int'($urandom_range(0, 12000)) - 6000)
                                 : (i == 3) ? t_coef'(int'($urandom_range(0, 16000)) - 8000)
                                 : t_coef'(int'($urandom_range(0, 8000)) - 4000);
                    end
                    default: coefs[i] = pick_wide_coef();
                endcase
                if (kind == 0 || $urandom_range(0, 9) < 7)
                    write_reg(t_cfg_index'(REG_IIR_B0 + i), coefs[i]);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, t_coef'($urandom));
            cfg_ch.valid <= 1'b0;

            n = $urandom_range(15, 60);
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phases == 6) begin
                // hold the output off while input keeps flowing
                gaps_on = 1'b0;
                n = 60;
                hold_off_len = HOLD_OFF_LEN;
            end
            repeat (n) send_sample(pick_sample());
            random_sent += n;
            settle();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("summary: %0d samples checked over %0d register settings, all four mode codes",
                 sb.checked, phases);
        $display("summary: %0d long output hold-off(s), %0d mismatch(es)",
                 hold_offs_done, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/ssf_pkg.sv
rtl/ssf_if.sv
rtl/ssf_cfg_regs.sv
rtl/ssf_filter.sv
rtl/selectable_smoothing_filter_core.sv
tb/testbench.sv
